[rtl/crcfp_pkg.sv]
package crcfp_pkg;

	localparam int PAYLOAD_DEPTH = 64;
	localparam int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_MSB  = 16'h8000;

	typedef enum logic [2:0] {
		EV_NONE = 3'd0,
		EV_OK   = 3'd1,
		EV_CRC  = 3'd2,
		EV_LEN  = 3'd3,
		EV_VER  = 3'd4,
		EV_SYNC = 3'd5
	} event_t;

	typedef enum logic [1:0] {
		REG_FIRST_SYNC  = 2'd0,
		REG_SECOND_SYNC = 2'd1,
		REG_VERSION     = 2'd2,
		REG_MAX_LEN     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] first_sync;
		logic [7:0] second_sync;
		logic [7:0] version;
		logic [6:0] max_len;
	} cfg_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic   crc_init;
		logic   crc_upd;
		logic   ld_type;
		logic   ld_seq0;
		logic   ld_seq1;
		logic   ld_len;
		logic   ld_crc_low;
		logic   wr_payload;
		logic   emit_clr;
		logic   rd_en;
		logic   out_ld;
		logic   out_frame;
		logic   out_emit;
		event_t out_ev;
		logic   inc_good;
		logic   inc_crc;
		logic   inc_len;
		logic   inc_ver;
		logic   inc_resync;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic eq_first;
		logic eq_second;
		logic eq_version;
		logic len_bad;
		logic len_zero;
		logic fill_last;
		logic crc_match;
		logic held_len_zero;
		logic emit_last;
		logic out_free;
	} sts_t;

	// CRC-16 CCITT, one byte, MSB first
	function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_MSB) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

[rtl/crcfp_if.sv]
interface crcfp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface crcfp_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic [7:0]  frame_type;
	logic [15:0] seq_number;
	logic [6:0]  payload_len;
	logic [5:0]  byte_position;
	logic [7:0]  payload_byte;
	logic        last;
	logic [31:0] good_frames;
	logic [31:0] crc_errors;
	logic [31:0] length_errors;
	logic [31:0] version_errors;
	logic [31:0] resyncs;

	modport source (
		output valid, output event_res, output frame_type, output seq_number,
		output payload_len, output byte_position, output payload_byte, output last,
		output good_frames, output crc_errors, output length_errors,
		output version_errors, output resyncs, input ready
	);
	modport sink (
		input valid, input event_res, input frame_type, input seq_number,
		input payload_len, input byte_position, input payload_byte, input last,
		input good_frames, input crc_errors, input length_errors,
		input version_errors, input resyncs, output ready
	);
endinterface

[rtl/crcfp_regs.sv]
module crcfp_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output crcfp_pkg::cfg_t   cfg
);
	import crcfp_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_sync  <= 8'h00;
			cfg_q.second_sync <= 8'h00;
			cfg_q.version     <= 8'h00;
			cfg_q.max_len     <= 7'd64;
		end else if (wr) begin
			case (idx)
				REG_FIRST_SYNC:  cfg_q.first_sync  <= pwdata[7:0];
				REG_SECOND_SYNC: cfg_q.second_sync <= pwdata[7:0];
				REG_VERSION:     cfg_q.version     <= pwdata[7:0];
				REG_MAX_LEN:     cfg_q.max_len     <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_FIRST_SYNC:  prdata = {24'h0, cfg_q.first_sync};
			REG_SECOND_SYNC: prdata = {24'h0, cfg_q.second_sync};
			REG_VERSION:     prdata = {24'h0, cfg_q.version};
			REG_MAX_LEN:     prdata = {25'h0, cfg_q.max_len};
			default:         prdata = 32'h0;
		endcase
	end

endmodule

[rtl/crcfp_ctrl.sv]
module crcfp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rx_valid,
	output logic              rx_ready,
	input  crcfp_pkg::sts_t   sts,
	output crcfp_pkg::cmd_t   cmd
);
	import crcfp_pkg::*;

	typedef enum logic [11:0] {
		ST_MAGIC0  = 12'b0000_0000_0001,
		ST_MAGIC1  = 12'b0000_0000_0010,
		ST_VERSION = 12'b0000_0000_0100,
		ST_TYPE    = 12'b0000_0000_1000,
		ST_SEQ0    = 12'b0000_0001_0000,
		ST_SEQ1    = 12'b0000_0010_0000,
		ST_LENGTH  = 12'b0000_0100_0000,
		ST_PAYLOAD = 12'b0000_1000_0000,
		ST_CRC0    = 12'b0001_0000_0000,
		ST_CRC1    = 12'b0010_0000_0000,
		ST_RD      = 12'b0100_0000_0000,
		ST_EMIT    = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d, restart;
	logic   parse, accept;

	assign parse    = (state_q != ST_RD) && (state_q != ST_EMIT);
	assign rx_ready = parse & sts.out_free;
	assign accept   = rx_valid & rx_ready;
	// after an error, a failing byte equal to the first magic counts as one
	assign restart  = sts.eq_first ? ST_MAGIC1 : ST_MAGIC0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_MAGIC0;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.out_ev = EV_NONE;
		if (parse && accept) begin
			cmd.out_ld = 1'b1;
		end
		case (state_q)
			ST_MAGIC0: begin
				if (accept && sts.eq_first) begin
					state_d = ST_MAGIC1;
				end
			end
			ST_MAGIC1: begin
				if (accept) begin
					if (sts.eq_second) begin
						state_d = ST_VERSION;
					end else if (!sts.eq_first) begin
						state_d        = ST_MAGIC0;
						cmd.inc_resync = 1'b1;
						cmd.out_ev     = EV_SYNC;
					end
				end
			end
			ST_VERSION: begin
				if (accept) begin
					if (!sts.eq_version) begin
						state_d        = restart;
						cmd.inc_ver    = 1'b1;
						cmd.inc_resync = 1'b1;
						cmd.out_ev     = EV_VER;
					end else begin
						state_d      = ST_TYPE;
						cmd.crc_init = 1'b1;
						cmd.crc_upd  = 1'b1;
					end
				end
			end
			ST_TYPE: begin
				if (accept) begin
					state_d     = ST_SEQ0;
					cmd.ld_type = 1'b1;
					cmd.crc_upd = 1'b1;
				end
			end
			ST_SEQ0: begin
				if (accept) begin
					state_d     = ST_SEQ1;
					cmd.ld_seq0 = 1'b1;
					cmd.crc_upd = 1'b1;
				end
			end
			ST_SEQ1: begin
				if (accept) begin
					state_d     = ST_LENGTH;
					cmd.ld_seq1 = 1'b1;
					cmd.crc_upd = 1'b1;
				end
			end
			ST_LENGTH: begin
				if (accept) begin
					if (sts.len_bad) begin
						state_d        = restart;
						cmd.inc_len    = 1'b1;
						cmd.inc_resync = 1'b1;
						cmd.out_ev     = EV_LEN;
					end else begin
						state_d     = sts.len_zero ? ST_CRC0 : ST_PAYLOAD;
						cmd.ld_len  = 1'b1;
						cmd.crc_upd = 1'b1;
					end
				end
			end
			ST_PAYLOAD: begin
				if (accept) begin
					cmd.wr_payload = 1'b1;
					cmd.crc_upd    = 1'b1;
					if (sts.fill_last) begin
						state_d = ST_CRC0;
					end
				end
			end
			ST_CRC0: begin
				if (accept) begin
					state_d        = ST_CRC1;
					cmd.ld_crc_low = 1'b1;
				end
			end
			ST_CRC1: begin
				if (accept) begin
					if (!sts.crc_match) begin
						state_d        = restart;
						cmd.inc_crc    = 1'b1;
						cmd.inc_resync = 1'b1;
						cmd.out_ev     = EV_CRC;
					end else if (sts.held_len_zero) begin
						state_d       = ST_MAGIC0;
						cmd.inc_good  = 1'b1;
						cmd.out_ev    = EV_OK;
						cmd.out_frame = 1'b1;
					end else begin
						// payload run follows, no result for this byte yet
						state_d      = ST_RD;
						cmd.inc_good = 1'b1;
						cmd.emit_clr = 1'b1;
						cmd.out_ld   = 1'b0;
					end
				end
			end
			ST_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.out_ld    = 1'b1;
					cmd.out_emit  = 1'b1;
					cmd.out_frame = 1'b1;
					cmd.out_ev    = EV_OK;
					state_d       = sts.emit_last ? ST_MAGIC0 : ST_RD;
				end
			end
			default: begin
				state_d = ST_MAGIC0;
			end
		endcase
	end

endmodule

[rtl/crcfp_dp.sv]
module crcfp_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        rx_byte,
	input  crcfp_pkg::cfg_t   cfg,
	input  crcfp_pkg::cmd_t   cmd,
	output crcfp_pkg::sts_t   sts,
	input  logic              res_ready,
	output logic              res_valid,
	output logic [2:0]        event_res,
	output logic [7:0]        frame_type,
	output logic [15:0]       seq_number,
	output logic [6:0]        payload_len,
	output logic [5:0]        byte_position,
	output logic [7:0]        payload_byte,
	output logic              last,
	output logic [31:0]       good_frames,
	output logic [31:0]       crc_errors,
	output logic [31:0]       length_errors,
	output logic [31:0]       version_errors,
	output logic [31:0]       resyncs
);
	import crcfp_pkg::*;

	logic [7:0]        type_q;
	logic [15:0]       seq_q;
	logic [6:0]        len_q;
	logic [6:0]        fill_q;
	logic [15:0]       crc_q;
	logic [7:0]        crc_low_q;
	logic [ADDR_W-1:0] emit_idx_q;
	logic [7:0]        rd_data_q;
	logic [7:0]        mem [PAYLOAD_DEPTH];

	logic [31:0] good_q, crc_err_q, len_err_q, ver_err_q, resync_q;

	logic        out_valid_q;
	event_t      out_ev_q;
	logic        out_frame_q;
	logic [5:0]  out_pos_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;

	logic [7:0]  limit;

	// effective length limit is the smaller of the register and the buffer
	assign limit = ({1'b0, cfg.max_len} > 8'(PAYLOAD_DEPTH)) ? 8'(PAYLOAD_DEPTH)
		: {1'b0, cfg.max_len};

	assign sts.eq_first      = (rx_byte == cfg.first_sync);
	assign sts.eq_second     = (rx_byte == cfg.second_sync);
	assign sts.eq_version    = (rx_byte == cfg.version);
	assign sts.len_bad       = (rx_byte > limit);
	assign sts.len_zero      = (rx_byte == 8'h00);
	assign sts.fill_last     = ((fill_q + 7'd1) >= len_q);
	assign sts.crc_match     = ({rx_byte, crc_low_q} == crc_q);
	assign sts.held_len_zero = (len_q == 7'd0);
	assign sts.emit_last     = ((7'(emit_idx_q) + 7'd1) == len_q);
	assign sts.out_free      = ~out_valid_q | res_ready;

	// frame header and CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q    <= 8'h00;
			seq_q     <= 16'h0000;
			len_q     <= 7'd0;
			fill_q    <= 7'd0;
			crc_q     <= CRC_INIT;
			crc_low_q <= 8'h00;
		end else begin
			if (cmd.ld_type) begin
				type_q <= rx_byte;
			end
			if (cmd.ld_seq0) begin
				seq_q <= {8'h00, rx_byte};
			end
			if (cmd.ld_seq1) begin
				seq_q[15:8] <= rx_byte;
			end
			if (cmd.ld_len) begin
				len_q  <= rx_byte[6:0];
				fill_q <= 7'd0;
			end
			if (cmd.wr_payload) begin
				fill_q <= fill_q + 7'd1;
			end
			if (cmd.crc_upd) begin
				crc_q <= crc_add(cmd.crc_init ? CRC_INIT : crc_q, rx_byte);
			end
			if (cmd.ld_crc_low) begin
				crc_low_q <= rx_byte;
			end
		end
	end

	// payload buffer
	always_ff @(posedge clk) begin
		if (cmd.wr_payload) begin
			mem[fill_q[ADDR_W-1:0]] <= rx_byte;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[emit_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_idx_q <= '0;
		end else if (cmd.emit_clr) begin
			emit_idx_q <= '0;
		end else if (cmd.out_emit) begin
			emit_idx_q <= emit_idx_q + 1'b1;
		end
	end

	// wrapping counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			good_q    <= 32'h0;
			crc_err_q <= 32'h0;
			len_err_q <= 32'h0;
			ver_err_q <= 32'h0;
			resync_q  <= 32'h0;
		end else begin
			if (cmd.inc_good) begin
				good_q <= good_q + 32'h1;
			end
			if (cmd.inc_crc) begin
				crc_err_q <= crc_err_q + 32'h1;
			end
			if (cmd.inc_len) begin
				len_err_q <= len_err_q + 32'h1;
			end
			if (cmd.inc_ver) begin
				ver_err_q <= ver_err_q + 32'h1;
			end
			if (cmd.inc_resync) begin
				resync_q <= resync_q + 32'h1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_ev_q    <= cmd.out_ev;
			out_frame_q <= cmd.out_frame;
			if (cmd.out_emit) begin
				out_pos_q  <= 6'(emit_idx_q);
				out_byte_q <= rd_data_q;
				out_last_q <= sts.emit_last;
			end else begin
				out_pos_q  <= 6'd0;
				out_byte_q <= 8'h00;
				out_last_q <= 1'b1;
			end
		end
	end

	// header fields and counters only move on an accepted byte, which needs
	// the result register free, so they can be shown straight from state
	assign res_valid      = out_valid_q;
	assign event_res      = out_ev_q;
	assign frame_type     = out_frame_q ? type_q : 8'h00;
	assign seq_number     = out_frame_q ? seq_q : 16'h0000;
	assign payload_len    = out_frame_q ? len_q : 7'd0;
	assign byte_position  = out_pos_q;
	assign payload_byte   = out_byte_q;
	assign last           = out_last_q;
	assign good_frames    = good_q;
	assign crc_errors     = crc_err_q;
	assign length_errors  = len_err_q;
	assign version_errors = ver_err_q;
	assign resyncs        = resync_q;

endmodule

[rtl/crc_frame_receive_parser.sv]
// channel | dir | transfer moves
// --------+-----+---------------------------------------------------------
// rx      | in  | one received byte (rx_byte)
// res     | out | one result: event, frame header, payload byte, counters
// apb     | in  | register write/read, regs at byte address 4*i
//
// A byte that causes a single status result loads it into the result
// register as the byte is taken. The byte that closes a good frame with
// payload starts a run of results, each a buffer read and then a result
// register load, during which no byte is taken. Reset needs no clearing pass; the
// payload buffer is only read at entries written in the current frame.
// A result waiting in the output register blocks new bytes unless it is
// transferred in the same cycle.
module crc_frame_receive_parser (
	input  logic          clk,
	input  logic          arst_n,
	crcfp_rx_if.sink      rx,
	crcfp_res_if.source   res,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import crcfp_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	// configuration registers
	crcfp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// framing state machine and payload run sequencing
	crcfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx.valid),
		.rx_ready (rx.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// header capture, CRC, payload buffer, counters, result register
	crcfp_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx_byte        (rx.rx_byte),
		.cfg            (cfg),
		.cmd            (cmd),
		.sts            (sts),
		.res_ready      (res.ready),
		.res_valid      (res.valid),
		.event_res      (res.event_res),
		.frame_type     (res.frame_type),
		.seq_number     (res.seq_number),
		.payload_len    (res.payload_len),
		.byte_position  (res.byte_position),
		.payload_byte   (res.payload_byte),
		.last           (res.last),
		.good_frames    (res.good_frames),
		.crc_errors     (res.crc_errors),
		.length_errors  (res.length_errors),
		.version_errors (res.version_errors),
		.resyncs        (res.resyncs)
	);

endmodule

[sim/crc_frame_receive_parser_tb.sv]
`timescale 1ns / 1ps

// Self-checking bench for the framed-packet receive parser.
// Byte stream in on rx, results out on res, four registers over APB.
// A cycle-free software image of the parser runs beside the DUT: every rx
// transfer advances it and queues the results that byte must produce;
// every res transfer is checked against the head of that queue.
module crc_frame_receive_parser_tb;
	import crcfp_pkg::*;

	localparam int CLK_HALF        = 6;
	localparam int RESET_CYCLES    = 7;
	localparam int IDLE_LIMIT      = 3000;  // cycles with no transfer or register access at all
	localparam int MAX_REPORTED    = 10;
	localparam int DRAIN_CYCLES    = 20;
	localparam int HOLD_OFF_CYCLES = 200;

	// parser phases, in stream order
	typedef enum logic [3:0] {
		HUNT_FIRST,
		HUNT_SECOND,
		GET_VERSION,
		GET_TYPE,
		GET_SEQ_LO,
		GET_SEQ_HI,
		GET_LENGTH,
		GET_PAYLOAD,
		GET_CRC_LO,
		GET_CRC_HI
	} parse_phase_t;

	// how a generated frame is damaged, if at all
	typedef enum int {
		FAULT_NONE,
		FAULT_CRC,
		FAULT_VERSION,
		FAULT_LENGTH
	} frame_fault_t;

	typedef struct packed {
		logic [2:0]  ev;
		logic [7:0]  ftype;
		logic [15:0] seq;
		logic [6:0]  plen;
		logic [5:0]  pos;
		logic [7:0]  data;
		logic        is_last;
		logic [31:0] good;
		logic [31:0] crc_err;
		logic [31:0] len_err;
		logic [31:0] ver_err;
		logic [31:0] resync;
	} parse_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	crcfp_rx_if  rx_ch ();
	crcfp_res_if res_ch ();

	crc_frame_receive_parser u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #CLK_HALF clk = ~clk;

	// ---------------------------------------------------------------
	// Register shadow: updated at the edge that commits the APB write
	// ---------------------------------------------------------------
	logic [7:0] cfg_first;
	logic [7:0] cfg_second;
	logic [7:0] cfg_version;
	logic [6:0] cfg_max_len;

	// ---------------------------------------------------------------
	// Parser image
	// ---------------------------------------------------------------
	parse_phase_t phase;
	logic [7:0]   held_type;
	logic [15:0]  held_seq;
	logic [6:0]   held_len;
	logic [6:0]   fill_idx;
	logic [15:0]  crc_acc;
	logic [7:0]   crc_lo;
	logic [7:0]   payload_store [PAYLOAD_DEPTH];
	logic [31:0]  good_cnt;
	logic [31:0]  crc_error_cnt;
	logic [31:0]  length_error_cnt;
	logic [31:0]  version_error_cnt;
	logic [31:0]  resync_cnt;

	// results still owed by the DUT, oldest first
	parse_result_t results_due [$];

	int unsigned rx_count = 0;
	int unsigned result_count = 0;
	int unsigned mismatch_count = 0;
	int unsigned frames_sent = 0;
	int unsigned settings_count = 0;
	int unsigned idle_cycles = 0;

	// traffic shaping knobs, flipped by the tests
	bit          src_gaps_on = 1'b1;
	bit          sink_gaps_on = 1'b1;
	int unsigned hold_off_left = 0;
	int unsigned stall_left = 0;

	// CRC-16/CCITT-FALSE, one bit per step, MSB first
	function automatic logic [15:0] ccitt_next(input logic [15:0] crc, input logic [7:0] d);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb  = crc[15] ^ d[i];
			crc = {crc[14:0], 1'b0};
			if (fb) begin
				crc = crc ^ CRC_POLY;
			end
		end
		return crc;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int unsigned pick_gap(input bit enabled);
		int unsigned r;
		if (!enabled) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// largest length byte the parser takes; the buffer caps the register
	function automatic int unsigned length_cap();
		return (cfg_max_len > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : cfg_max_len;
	endfunction

	function automatic parse_result_t make_result(input logic [2:0] ev, input bit in_frame,
			input logic [5:0] pos, input logic [7:0] data, input logic is_last);
		parse_result_t r;
		r.ev      = ev;
		r.ftype   = in_frame ? held_type : 8'h00;
		r.seq     = in_frame ? held_seq : 16'h0000;
		r.plen    = in_frame ? held_len : 7'h00;
		r.pos     = pos;
		r.data    = data;
		r.is_last = is_last;
		r.good    = good_cnt;
		r.crc_err = crc_error_cnt;
		r.len_err = length_error_cnt;
		r.ver_err = version_error_cnt;
		r.resync  = resync_cnt;
		return r;
	endfunction

	function automatic string describe(input parse_result_t r);
		return $sformatf({"ev=%0d type=%02h seq=%04h len=%0d pos=%0d data=%02h last=%0b",
			" good=%0d crc=%0d len_err=%0d ver=%0d resync=%0d"},
			r.ev, r.ftype, r.seq, r.plen, r.pos, r.data, r.is_last,
			r.good, r.crc_err, r.len_err, r.ver_err, r.resync);
	endfunction

	function automatic void clear_frame();
		phase     = HUNT_FIRST;
		held_type = 8'h00;
		held_seq  = 16'h0000;
		held_len  = 7'h00;
		fill_idx  = 7'h00;
		crc_acc   = CRC_INIT;
		crc_lo    = 8'h00;
	endfunction

	// dropped frame: count the resync; a failing byte equal to the first
	// magic already counts as the start of the next frame
	function automatic void restart_hunt(input logic [7:0] b);
		resync_cnt++;
		clear_frame();
		if (b == cfg_first) begin
			phase = HUNT_SECOND;
		end
	endfunction

	// Advance the image by one accepted byte and queue what it owes.
	function automatic void advance_parser(input logic [7:0] b);
		logic [2:0]  ev;
		bit          burst;
		int unsigned n;
		ev    = EV_NONE;
		burst = 1'b0;
		case (phase)
			HUNT_FIRST: begin
				if (b == cfg_first) begin
					phase = HUNT_SECOND;
				end
			end
			HUNT_SECOND: begin
				// second magic wins over a repeated first magic
				if (b == cfg_second) begin
					phase = GET_VERSION;
				end else if (b != cfg_first) begin
					phase = HUNT_FIRST;
					resync_cnt++;
					ev = EV_SYNC;
				end
			end
			GET_VERSION: begin
				if (b != cfg_version) begin
					version_error_cnt++;
					restart_hunt(b);
					ev = EV_VER;
				end else begin
					crc_acc = ccitt_next(CRC_INIT, b);
					phase   = GET_TYPE;
				end
			end
			GET_TYPE: begin
				held_type = b;
				crc_acc   = ccitt_next(crc_acc, b);
				phase     = GET_SEQ_LO;
			end
			GET_SEQ_LO: begin
				held_seq = {8'h00, b};
				crc_acc  = ccitt_next(crc_acc, b);
				phase    = GET_SEQ_HI;
			end
			GET_SEQ_HI: begin
				held_seq[15:8] = b;
				crc_acc        = ccitt_next(crc_acc, b);
				phase          = GET_LENGTH;
			end
			GET_LENGTH: begin
				if (b > length_cap()) begin
					length_error_cnt++;
					restart_hunt(b);
					ev = EV_LEN;
				end else begin
					held_len = b[6:0];
					fill_idx = 7'h00;
					crc_acc  = ccitt_next(crc_acc, b);
					phase    = (b == 8'h00) ? GET_CRC_LO : GET_PAYLOAD;
				end
			end
			GET_PAYLOAD: begin
				if (fill_idx < PAYLOAD_DEPTH) begin
					payload_store[fill_idx] = b;
				end
				fill_idx = fill_idx + 7'd1;
				crc_acc  = ccitt_next(crc_acc, b);
				if (fill_idx >= held_len) begin
					phase = GET_CRC_LO;
				end
			end
			GET_CRC_LO: begin
				crc_lo = b;
				phase  = GET_CRC_HI;
			end
			GET_CRC_HI: begin
				if ({b, crc_lo} != crc_acc) begin
					crc_error_cnt++;
					restart_hunt(b);
					ev = EV_CRC;
				end else begin
					// good frame: one result per payload byte, or a single
					// header-only result for an empty payload
					good_cnt++;
					n = (held_len > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : held_len;
					if (n == 0) begin
						results_due.push_back(make_result(EV_OK, 1'b1, 6'd0, 8'h00, 1'b1));
					end else begin
						for (int k = 0; k < n; k++) begin
							results_due.push_back(make_result(EV_OK, 1'b1, k[5:0],
								payload_store[k], k == n - 1));
						end
					end
					clear_frame();
					burst = 1'b1;
				end
			end
			default: begin
				clear_frame();
			end
		endcase
		if (!burst) begin
			results_due.push_back(make_result(ev, 1'b0, 6'd0, 8'h00, 1'b1));
		end
	endfunction

	// ---------------------------------------------------------------
	// Stimulus primitives
	// ---------------------------------------------------------------

	// Offer one byte, wait for its transfer, then book its results.
	// valid stays high across back-to-back bytes.
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		gap = pick_gap(src_gaps_on);
		if (gap != 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do begin
			@(posedge clk);
		end while (!rx_ch.ready);
		advance_parser(b);
		rx_count++;
	endtask

	// Build a frame under the current settings and send it. Version and
	// length faults cut the frame at the failing byte; what would follow
	// is noise to the parser anyway.
	task automatic send_frame(input frame_fault_t fault, input int unsigned len,
			input logic [7:0] ftype, input logic [15:0] seq);
		logic [7:0]  wire_bytes [$];
		logic [7:0]  ver;
		logic [7:0]  len_byte;
		logic [7:0]  pb;
		logic [15:0] crc;
		logic [15:0] sent_crc;
		ver      = cfg_version;
		len_byte = len[7:0];
		if (fault == FAULT_VERSION) begin
			ver = cfg_version ^ 8'($urandom_range(1, 255));
		end
		if (fault == FAULT_LENGTH) begin
			len_byte = 8'($urandom_range(length_cap() + 1, 255));
		end
		wire_bytes = {cfg_first, cfg_second, ver};
		if (fault != FAULT_VERSION) begin
			wire_bytes = {wire_bytes, ftype, seq[7:0], seq[15:8], len_byte};
			if (fault != FAULT_LENGTH) begin
				for (int i = 0; i < len; i++) begin
					pb = 8'($urandom_range(0, 255));
					wire_bytes.push_back(pb);
				end
				crc = CRC_INIT;
				for (int i = 2; i < wire_bytes.size(); i++) begin
					crc = ccitt_next(crc, wire_bytes[i]);
				end
				sent_crc = crc;
				if (fault == FAULT_CRC) begin
					// sometimes make the failing high byte the first magic
					if ($urandom_range(0, 2) == 0) begin
						sent_crc[15:8] = cfg_first;
					end else begin
						sent_crc = sent_crc ^ 16'($urandom_range(1, 65535));
					end
					if (sent_crc == crc) begin
						sent_crc[7:0] = sent_crc[7:0] ^ 8'($urandom_range(1, 255));
					end
				end
				wire_bytes = {wire_bytes, sent_crc[7:0], sent_crc[15:8]};
			end
		end
		foreach (wire_bytes[i]) begin
			send_byte(wire_bytes[i]);
		end
		frames_sent++;
	endtask

	// Stop offering and wait until the DUT owes nothing; every byte has a
	// result, so an empty queue means the parser is idle.
	task automatic wait_drained();
		rx_ch.valid <= 1'b0;
		while (results_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// APB write: setup, access; the register takes the value at the
	// access edge. The bus then idles so the next access starts clean.
	task automatic write_register(input reg_idx_t idx, input logic [7:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'h000000, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_FIRST_SYNC:  cfg_first   = value;
			REG_SECOND_SYNC: cfg_second  = value;
			REG_VERSION:     cfg_version = value;
			REG_MAX_LEN:     cfg_max_len = value[6:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic read_register(input reg_idx_t idx, input logic [7:0] want);
		logic [7:0] mask;
		logic [7:0] got;
		mask    = (idx == REG_MAX_LEN) ? 8'h7F : 8'hFF;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got     = prdata[7:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		if ((got & mask) !== (want & mask)) begin
			if (mismatch_count < MAX_REPORTED) begin
				$display("register %s read back %02h, expected %02h",
					idx.name(), got & mask, want & mask);
			end
			mismatch_count++;
		end
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [7:0] first, input logic [7:0] second,
			input logic [7:0] version, input logic [6:0] max_len);
		wait_drained();
		write_register(REG_FIRST_SYNC, first);
		write_register(REG_SECOND_SYNC, second);
		write_register(REG_VERSION, version);
		write_register(REG_MAX_LEN, {1'b0, max_len});
		read_register(REG_FIRST_SYNC, cfg_first);
		read_register(REG_SECOND_SYNC, cfg_second);
		read_register(REG_VERSION, cfg_version);
		read_register(REG_MAX_LEN, {1'b0, cfg_max_len});
		settings_count++;
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// reset values read back, then the setting used by the directed tests
	task automatic test_register_access();
		read_register(REG_FIRST_SYNC, 8'h00);
		read_register(REG_SECOND_SYNC, 8'h00);
		read_register(REG_VERSION, 8'h00);
		read_register(REG_MAX_LEN, 8'd64);
		apply_settings(8'hA5, 8'h5A, 8'h01, 7'd64);
	endtask

	// Hunt behavior: repeated first magic, sync loss, version error on a
	// plain byte and on the first magic, length error on the first magic.
	task automatic test_sync_hunt();
		logic [7:0] stream [$];
		stream = {8'hFF, 8'hA5, 8'hA5, 8'h00,
			8'hA5, 8'h5A, 8'h02,
			8'hA5, 8'h5A, 8'hA5,
			8'h5A, 8'h01, 8'h00, 8'h00, 8'h00, 8'hA5};
		foreach (stream[i]) begin
			send_byte(stream[i]);
		end
	endtask

	// empty payload, single byte payload, bad checksum
	task automatic test_directed_frames();
		send_frame(FAULT_NONE, 0, 8'hFF, 16'h00FF);
		send_frame(FAULT_NONE, 1, 8'h00, 16'hFFFF);
		send_frame(FAULT_CRC, 2, 8'h3C, 16'h8001);
	endtask

	// Mostly frames with random content (some damaged), the rest noise
	// built from sync, version and arbitrary bytes.
	task automatic test_random_traffic(input logic [7:0] first, input logic [7:0] second,
			input logic [7:0] version, input logic [6:0] max_len,
			input int unsigned budget, input bit gaps);
		int unsigned start;
		int unsigned r;
		int unsigned cap;
		int unsigned len;
		frame_fault_t fault;
		apply_settings(first, second, version, max_len);
		src_gaps_on  = gaps;
		sink_gaps_on = gaps;
		start = rx_count;
		while (rx_count - start < budget) begin
			r = $urandom_range(0, 99);
			if (r < 25) begin
				repeat ($urandom_range(1, 3)) begin
					case ($urandom_range(0, 3))
						0: send_byte(cfg_first);
						1: send_byte(cfg_second);
						2: send_byte(cfg_version);
						default: send_byte(8'($urandom_range(0, 255)));
					endcase
				end
			end else begin
				r = $urandom_range(0, 99);
				fault = (r < 60) ? FAULT_NONE : (r < 75) ? FAULT_CRC :
					(r < 87) ? FAULT_VERSION : FAULT_LENGTH;
				cap = length_cap();
				if (cap == 0) begin
					len = 0;
				end else if ($urandom_range(0, 99) < 85) begin
					len = $urandom_range(0, (cap < 6) ? cap : 6);
				end else begin
					len = $urandom_range(0, cap);
				end
				send_frame(fault, len, 8'($urandom_range(0, 255)),
					16'($urandom_range(0, 65535)));
			end
		end
		src_gaps_on  = 1'b1;
		sink_gaps_on = 1'b1;
	endtask

	// Receiver holds off while a full-size frame streams in with no gaps:
	// the output register fills and rx must stall. Then a length byte
	// above the buffer depth.
	task automatic test_backpressure();
		src_gaps_on   = 1'b0;
		hold_off_left <= HOLD_OFF_CYCLES;
		send_frame(FAULT_NONE, PAYLOAD_DEPTH, 8'($urandom_range(0, 255)),
			16'($urandom_range(0, 65535)));
		src_gaps_on = 1'b1;
		send_frame(FAULT_LENGTH, 0, 8'h00, 16'h0000);
		send_frame(FAULT_NONE, 3, 8'h81, 16'h1234);
	endtask

	// ---------------------------------------------------------------
	// Result side: ready pattern and checking
	// ---------------------------------------------------------------

	// A requested hold-off beats the random stalls; both count down here.
	always @(posedge clk) begin
		if (hold_off_left != 0) begin
			res_ch.ready  <= 1'b0;
			hold_off_left <= hold_off_left - 1;
		end else if (stall_left != 0) begin
			res_ch.ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else begin
			res_ch.ready <= 1'b1;
			if (sink_gaps_on && $urandom_range(0, 3) == 0) begin
				stall_left <= pick_gap(1'b1);
			end
		end
	end

	// Sample at the edge: values seen here are the ones the transfer used.
	always @(posedge clk) begin
		parse_result_t got;
		parse_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.ev      = res_ch.event_res;
			got.ftype   = res_ch.frame_type;
			got.seq     = res_ch.seq_number;
			got.plen    = res_ch.payload_len;
			got.pos     = res_ch.byte_position;
			got.data    = res_ch.payload_byte;
			got.is_last = res_ch.last;
			got.good    = res_ch.good_frames;
			got.crc_err = res_ch.crc_errors;
			got.len_err = res_ch.length_errors;
			got.ver_err = res_ch.version_errors;
			got.resync  = res_ch.resyncs;
			result_count++;
			if (results_due.size() == 0) begin
				if (mismatch_count < MAX_REPORTED) begin
					$display("unexpected result: %s", describe(got));
				end
				mismatch_count++;
			end else begin
				want = results_due.pop_front();
				if (got.ev !== want.ev || got.ftype !== want.ftype || got.seq !== want.seq ||
						got.plen !== want.plen || got.pos !== want.pos ||
						got.data !== want.data || got.is_last !== want.is_last ||
						got.good !== want.good || got.crc_err !== want.crc_err ||
						got.len_err !== want.len_err || got.ver_err !== want.ver_err ||
						got.resync !== want.resync) begin
					if (mismatch_count < MAX_REPORTED) begin
						$display("result %0d mismatch", result_count);
						$display("  expected %s", describe(want));
						$display("  actual   %s", describe(got));
					end
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: any transfer or register access resets the idle count.
	always @(posedge clk) begin
		if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) || psel) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles, %0d results still owed",
					IDLE_LIMIT, results_due.size());
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n        = 1'b0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = 8'h00;
		res_ch.ready  = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = 4'h0;
		pwdata        = 32'h0;
		// image starts in the reset state
		cfg_first         = 8'h00;
		cfg_second        = 8'h00;
		cfg_version       = 8'h00;
		cfg_max_len       = 7'd64;
		good_cnt          = 32'd0;
		crc_error_cnt     = 32'd0;
		length_error_cnt  = 32'd0;
		version_error_cnt = 32'd0;
		resync_cnt        = 32'd0;
		foreach (payload_store[i]) begin
			payload_store[i] = 8'h00;
		end
		clear_frame();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_access();
		test_sync_hunt();
		test_directed_frames();
		// extremes of every register, then a random setting with the
		// length register above the buffer depth
		test_random_traffic(8'h00, 8'hFF, 8'hFF, 7'd8, 8, 1'b1);
		test_random_traffic(8'hFF, 8'h00, 8'h00, 7'd0, 6, 1'b0);
		test_random_traffic(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 7'd127, 8, 1'b1);
		test_backpressure();

		rx_ch.valid <= 1'b0;
		while (results_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d results from %0d bytes (%0d frames offered), %0d settings",
			result_count, rx_count, frames_sent, settings_count);
		$display("Parser saw %0d good frames, %0d crc, %0d length, %0d version errors, %0d resyncs",
			good_cnt, crc_error_cnt, length_error_cnt, version_error_cnt, resync_cnt);
		if (mismatch_count == 0 && results_due.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d results never seen", mismatch_count, results_due.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

[crc_frame_receive_parser.f]
rtl/crcfp_pkg.sv
rtl/crcfp_if.sv
rtl/crcfp_regs.sv
rtl/crcfp_ctrl.sv
rtl/crcfp_dp.sv
rtl/crc_frame_receive_parser.sv
sim/crc_frame_receive_parser_tb.sv
